// ===== design/ieqks_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ieqks_pkg: shared types and constants for the input event queue
// Action codes, command format between front and back, result format.
// ----------------------------------------------------------------------------
package ieqks_pkg;

	localparam int RING_DEPTH_DEF = 64;
	localparam int KEY_COUNT_DEF  = 768;
	localparam int CMDQ_DEPTH     = 4;

	localparam logic [2:0] ACT_PUSH = 3'd0;
	localparam logic [2:0] ACT_KEY  = 3'd1;
	localparam logic [2:0] ACT_SYNC = 3'd2;
	localparam logic [2:0] ACT_READ = 3'd3;
	localparam logic [2:0] ACT_TICK = 3'd4;

	localparam logic [15:0] TYPE_KEY    = 16'd1;
	localparam logic [15:0] TYPE_SYNC   = 16'd0;
	localparam logic [15:0] CODE_REPORT = 16'd0;

	localparam logic signed [31:0] VAL_RELEASE = 32'sd0;
	localparam logic signed [31:0] VAL_PRESS   = 32'sd1;
	localparam logic signed [31:0] VAL_REPEAT  = 32'sd2;

	// tick / 100 == (tick * DIV_MUL) >> DIV_SHIFT for every 32-bit tick
	localparam logic [31:0] DIV_MUL       = 32'd1374389535;
	localparam int          DIV_SHIFT     = 37;
	localparam logic [31:0] TICK_HZ       = 32'd100;
	localparam logic [19:0] USEC_PER_TICK = 20'd10000;

	typedef enum logic [1:0] {
		CMD_NOP,
		CMD_ENQ,
		CMD_READ,
		CMD_TICK
	} cmd_op_t;

	typedef struct packed {
		cmd_op_t            op;
		logic [15:0]        ev_type;
		logic [15:0]        ev_code;
		logic signed [31:0] ev_value;
		logic [5:0]         rcount;
	} cmd_t;

	typedef enum logic {
		BK_IDLE,
		BK_READ
	} bk_state_t;

	typedef struct packed {
		logic       accepted;
		logic       item_valid;
		logic       dropped;
		logic       last;
		logic [5:0] fill;
	} meta_t;

	typedef struct packed {
		logic               accepted;
		logic               item_valid;
		logic [15:0]        out_type;
		logic [15:0]        out_code;
		logic signed [31:0] out_value;
		logic [25:0]        ts_sec;
		logic [19:0]        ts_usec;
		logic [5:0]         fill_count;
		logic               dropped_oldest;
		logic               last;
	} result_t;

endpackage
`default_nettype wire

// ===== design/ieqks_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ieqks_front: command intake and key state tracking
// Takes items, does the key map read-modify-write and issues commands.
// ----------------------------------------------------------------------------
module ieqks_front #(
	parameter int KEY_COUNT = ieqks_pkg::KEY_COUNT_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	input  wire logic [2:0]         action,
	input  wire logic [15:0]        event_type,
	input  wire logic [15:0]        event_code,
	input  wire logic signed [31:0] event_value,
	input  wire logic               key_pressed,
	input  wire logic [5:0]         read_count,
	input  wire logic               q_full,
	output logic                    busy,
	output logic                    q_push,
	output ieqks_pkg::cmd_t         q_cmd
);
	import ieqks_pkg::*;

	localparam int KW = $clog2(KEY_COUNT);

	logic key_mem [KEY_COUNT];

	logic               clr_q;
	logic [KW-1:0]      clr_addr_q;
	logic               valid_s1;
	logic [2:0]         act_s1;
	logic [15:0]        type_s1;
	logic [15:0]        code_s1;
	logic signed [31:0] value_s1;
	logic               pressed_s1;
	logic [5:0]         rcount_s1;
	logic               in_range_s1;
	logic               held_s1;
	logic               accept;
	logic               key_go;
	logic               key_we;

	assign busy   = clr_q | valid_s1;
	assign accept = start & ~busy;
	assign q_push = valid_s1 & ~q_full;
	assign key_go = in_range_s1 & (pressed_s1 | held_s1);
	assign key_we = q_push & (act_s1 == ACT_KEY) & key_go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q      <= 1'b1;
			clr_addr_q <= '0;
			valid_s1   <= 1'b0;
		end else begin
			if (clr_q) begin
				clr_addr_q <= clr_addr_q + 1'b1;
				if (clr_addr_q == KW'(KEY_COUNT - 1)) begin
					clr_q <= 1'b0;
				end
			end
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (q_push) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			act_s1      <= action;
			type_s1     <= event_type;
			code_s1     <= event_code;
			value_s1    <= event_value;
			pressed_s1  <= key_pressed;
			rcount_s1   <= read_count;
			in_range_s1 <= event_code < 16'(KEY_COUNT);
		end
	end

	// key map: one write port (clear sweep or update), one registered read
	always_ff @(posedge clk) begin
		if (clr_q) begin
			key_mem[clr_addr_q] <= 1'b0;
		end else if (key_we) begin
			key_mem[code_s1[KW-1:0]] <= pressed_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			held_s1 <= key_mem[event_code[KW-1:0]];
		end
	end

	always_comb begin
		q_cmd          = '0;
		q_cmd.op       = CMD_NOP;
		q_cmd.ev_code  = code_s1;
		q_cmd.rcount   = rcount_s1;
		case (act_s1)
			ACT_PUSH: begin
				q_cmd.op       = CMD_ENQ;
				q_cmd.ev_type  = type_s1;
				q_cmd.ev_value = value_s1;
			end
			ACT_KEY: begin
				if (key_go) begin
					q_cmd.op      = CMD_ENQ;
					q_cmd.ev_type = TYPE_KEY;
					if (!pressed_s1) begin
						q_cmd.ev_value = VAL_RELEASE;
					end else if (held_s1) begin
						q_cmd.ev_value = VAL_REPEAT;
					end else begin
						q_cmd.ev_value = VAL_PRESS;
					end
				end
			end
			ACT_SYNC: begin
				q_cmd.op      = CMD_ENQ;
				q_cmd.ev_type = TYPE_SYNC;
				q_cmd.ev_code = CODE_REPORT;
			end
			ACT_READ: begin
				q_cmd.op = CMD_READ;
			end
			ACT_TICK: begin
				q_cmd.op = CMD_TICK;
			end
			default: begin
				q_cmd.op = CMD_NOP;
			end
		endcase
	end

endmodule
`default_nettype wire

// ===== design/ieqks_cmd_fifo.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ieqks_cmd_fifo: command queue between front and back
// Small register FIFO, head visible without a pop.
// ----------------------------------------------------------------------------
module ieqks_cmd_fifo (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire ieqks_pkg::cmd_t  push_cmd,
	input  wire logic             pop,
	output logic                  full,
	output logic                  empty,
	output ieqks_pkg::cmd_t       head
);
	import ieqks_pkg::*;

	localparam int QW = $clog2(CMDQ_DEPTH);

	cmd_t        entry_q [CMDQ_DEPTH];
	logic [QW-1:0] wr_q;
	logic [QW-1:0] rd_q;
	logic [QW:0]   cnt_q;

	assign full  = cnt_q == (QW + 1)'(CMDQ_DEPTH);
	assign empty = cnt_q == '0;
	assign head  = entry_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_q] <= push_cmd;
		end
	end

endmodule
`default_nettype wire

// ===== design/ieqks_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ieqks_back: ring buffer, tick counter and result pipeline
// Executes queued commands; reads stream one event per cycle.
// ----------------------------------------------------------------------------
module ieqks_back #(
	parameter int RING_DEPTH = ieqks_pkg::RING_DEPTH_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             q_empty,
	input  wire ieqks_pkg::cmd_t  q_head,
	output logic                  q_pop,
	output logic                  res_strobe,
	output ieqks_pkg::result_t    res
);
	import ieqks_pkg::*;

	localparam int PW = $clog2(RING_DEPTH);
	localparam int NW = (PW > 6) ? PW : 6;

	logic [63:0] ring_ev [RING_DEPTH];
	logic [31:0] ring_tm [RING_DEPTH];

	bk_state_t   state_q, state_d;
	logic [PW-1:0] wp_q, wp_d, rp_q, rp_d, cnt_q, cnt_d;
	logic [PW-1:0] wp_inc, rp_inc;
	logic [31:0] tick_q, tick_d;
	logic [5:0]  rem_q, rem_d;
	logic [5:0]  n_pop;
	logic        ring_full;
	logic        mem_we, mem_re;
	logic        iss_v;
	meta_t       iss_m;

	logic        v_s1, v_s2, v_s3;
	meta_t       m_s1, m_s2, m_s3;
	logic [63:0] ev_s1, ev_s2, ev_s3;
	logic [31:0] tm_s1, tm_s2, tm_s3;
	logic [63:0] prod_s2;
	logic [25:0] q_s3;
	logic [31:0] qx100;
	logic [6:0]  rem_ticks;
	logic        res_v_q;
	result_t     res_q;

	assign wp_inc    = (wp_q == PW'(RING_DEPTH - 1)) ? '0 : wp_q + 1'b1;
	assign rp_inc    = (rp_q == PW'(RING_DEPTH - 1)) ? '0 : rp_q + 1'b1;
	assign ring_full = cnt_q == PW'(RING_DEPTH - 1);
	assign n_pop     = (NW'(q_head.rcount) < NW'(cnt_q)) ? q_head.rcount : 6'(cnt_q);

	always_comb begin
		state_d = state_q;
		case (state_q)
			BK_IDLE: begin
				if (!q_empty && q_head.op == CMD_READ && n_pop != '0) begin
					state_d = BK_READ;
				end
			end
			BK_READ: begin
				if (rem_q == 6'd1) begin
					state_d = BK_IDLE;
				end
			end
			default: state_d = BK_IDLE;
		endcase
	end

	always_comb begin
		q_pop  = 1'b0;
		iss_v  = 1'b0;
		iss_m  = '0;
		mem_we = 1'b0;
		mem_re = 1'b0;
		wp_d   = wp_q;
		rp_d   = rp_q;
		cnt_d  = cnt_q;
		tick_d = tick_q;
		rem_d  = rem_q;
		case (state_q)
			BK_IDLE: begin
				if (!q_empty) begin
					q_pop      = 1'b1;
					iss_v      = 1'b1;
					iss_m.last = 1'b1;
					case (q_head.op)
						CMD_ENQ: begin
							mem_we         = 1'b1;
							wp_d           = wp_inc;
							iss_m.accepted = 1'b1;
							iss_m.dropped  = ring_full;
							if (ring_full) begin
								rp_d = rp_inc;
							end else begin
								cnt_d = cnt_q + 1'b1;
							end
							iss_m.fill = 6'(cnt_d);
						end
						CMD_READ: begin
							if (n_pop == '0) begin
								iss_m.fill = 6'(cnt_q);
							end else begin
								iss_v = 1'b0;
								rem_d = n_pop;
								cnt_d = cnt_q - PW'(n_pop);
							end
						end
						CMD_TICK: begin
							tick_d     = tick_q + 1'b1;
							iss_m.fill = 6'(cnt_q);
						end
						default: begin
							iss_m.fill = 6'(cnt_q);
						end
					endcase
				end
			end
			BK_READ: begin
				iss_v            = 1'b1;
				mem_re           = 1'b1;
				iss_m.item_valid = 1'b1;
				iss_m.last       = rem_q == 6'd1;
				iss_m.fill       = 6'(cnt_q);
				rp_d             = rp_inc;
				rem_d            = rem_q - 1'b1;
			end
			default: begin
				rem_d = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
			wp_q    <= '0;
			rp_q    <= '0;
			cnt_q   <= '0;
			tick_q  <= '0;
			rem_q   <= '0;
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
			res_v_q <= 1'b0;
		end else begin
			state_q <= state_d;
			wp_q    <= wp_d;
			rp_q    <= rp_d;
			cnt_q   <= cnt_d;
			tick_q  <= tick_d;
			rem_q   <= rem_d;
			v_s1    <= iss_v;
			v_s2    <= v_s1;
			v_s3    <= v_s2;
			res_v_q <= v_s3;
		end
	end

	// ring storage: write at the write pointer, registered read at the read pointer
	always_ff @(posedge clk) begin
		if (mem_we) begin
			ring_ev[wp_q] <= {q_head.ev_type, q_head.ev_code, q_head.ev_value};
			ring_tm[wp_q] <= tick_q;
		end
		if (mem_re) begin
			ev_s1 <= ring_ev[rp_q];
			tm_s1 <= ring_tm[rp_q];
		end
	end

	// time conversion: reciprocal multiply, then remainder and scaling
	assign qx100     = 32'(q_s3) * TICK_HZ;
	assign rem_ticks = 7'(tm_s3 - qx100);

	always_ff @(posedge clk) begin
		m_s1    <= iss_m;
		m_s2    <= m_s1;
		ev_s2   <= ev_s1;
		tm_s2   <= tm_s1;
		prod_s2 <= {32'd0, tm_s1} * {32'd0, DIV_MUL};
		m_s3    <= m_s2;
		ev_s3   <= ev_s2;
		tm_s3   <= tm_s2;
		q_s3    <= 26'(prod_s2 >> DIV_SHIFT);

		res_q.accepted       <= m_s3.accepted;
		res_q.item_valid     <= m_s3.item_valid;
		res_q.fill_count     <= m_s3.fill;
		res_q.dropped_oldest <= m_s3.dropped;
		res_q.last           <= m_s3.last;
		if (m_s3.item_valid) begin
			res_q.out_type  <= ev_s3[63:48];
			res_q.out_code  <= ev_s3[47:32];
			res_q.out_value <= ev_s3[31:0];
			res_q.ts_sec    <= q_s3;
			res_q.ts_usec   <= 20'(rem_ticks * USEC_PER_TICK);
		end else begin
			res_q.out_type  <= '0;
			res_q.out_code  <= '0;
			res_q.out_value <= '0;
			res_q.ts_sec    <= '0;
			res_q.ts_usec   <= '0;
		end
	end

	assign res_strobe = res_v_q;
	assign res        = res_q;

endmodule
`default_nettype wire

// ===== design/input_event_queue_with_key_state_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// input_event_queue_with_key_state_top: timestamped input event queue
// Ring of events with drop-oldest, per-key pressed map and tick timebase.
// ----------------------------------------------------------------------------
// Results cannot be held off: each result is on the outputs for exactly one
// cycle, flagged by result_strobe, and must be taken then. A command transfer
// happens on a clock edge with start high and busy low. After reset busy
// stays high while the key map is swept to zero. Every item passes through
// the front in two steps (key map read, then decide and write back), and the
// front takes no new item until the last one has gone into the command queue.
// The back runs one queued command per cycle while it is not streaming a read
// and the queue is not empty; a read of n events pops its command and then
// holds the back for one ring port read per event. Each result passes the
// registered result pipeline after the back issues it (ring read, reciprocal
// multiply for the /100, quotient, remainder and microsecond scaling). A read
// yields min(read_count, fill) results, or one result with item_valid low
// when nothing is popped; fill_count on every result is the queue fill after
// the whole command. All other actions yield exactly one result.
// ----------------------------------------------------------------------------
module input_event_queue_with_key_state_top #(
	parameter int RING_DEPTH = ieqks_pkg::RING_DEPTH_DEF,
	parameter int KEY_COUNT  = ieqks_pkg::KEY_COUNT_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output logic                    busy,
	input  wire logic [2:0]         action,
	input  wire logic [15:0]        event_type,
	input  wire logic [15:0]        event_code,
	input  wire logic signed [31:0] event_value,
	input  wire logic               key_pressed,
	input  wire logic [5:0]         read_count,
	output logic                    result_strobe,
	output logic                    accepted,
	output logic                    item_valid,
	output logic [15:0]             out_type,
	output logic [15:0]             out_code,
	output logic signed [31:0]      out_value,
	output logic [25:0]             ts_sec,
	output logic [19:0]             ts_usec,
	output logic [5:0]              fill_count,
	output logic                    dropped_oldest,
	output logic                    last
);
	import ieqks_pkg::*;

	// front -> queue -> back
	logic    q_push, q_pop, q_full, q_empty;
	cmd_t    q_cmd, q_head;
	result_t res;

	ieqks_front #(
		.KEY_COUNT (KEY_COUNT)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.action      (action),
		.event_type  (event_type),
		.event_code  (event_code),
		.event_value (event_value),
		.key_pressed (key_pressed),
		.read_count  (read_count),
		.q_full      (q_full),
		.busy        (busy),
		.q_push      (q_push),
		.q_cmd       (q_cmd)
	);

	ieqks_cmd_fifo u_cmdq (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_cmd (q_cmd),
		.pop      (q_pop),
		.full     (q_full),
		.empty    (q_empty),
		.head     (q_head)
	);

	ieqks_back #(
		.RING_DEPTH (RING_DEPTH)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_empty    (q_empty),
		.q_head     (q_head),
		.q_pop      (q_pop),
		.res_strobe (result_strobe),
		.res        (res)
	);

	// result fields straight off the output register
	assign accepted       = res.accepted;
	assign item_valid     = res.item_valid;
	assign out_type       = res.out_type;
	assign out_code       = res.out_code;
	assign out_value      = res.out_value;
	assign ts_sec         = res.ts_sec;
	assign ts_usec        = res.ts_usec;
	assign fill_count     = res.fill_count;
	assign dropped_oldest = res.dropped_oldest;
	assign last           = res.last;

endmodule
`default_nettype wire

// ===== bench/input_event_queue_with_key_state_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// input_event_queue_with_key_state_top_tb: self-checking bench for the event queue
// A behavioral copy of the ring, key map and tick counter predicts every
// result. Results are checked field by field, in order. Stimulus runs in
// four phases: directed corner items, ring overflow, timebase and random traffic.
// ----------------------------------------------------------------------------
module input_event_queue_with_key_state_top_tb;
	import ieqks_pkg::*;

	localparam int RING_DEPTH     = RING_DEPTH_DEF;
	localparam int KEY_COUNT      = KEY_COUNT_DEF;
	// Longest correct stretch with no transfer is the key map sweep after
	// reset. Sender gaps and the drain wait are far shorter.
	localparam int WATCHDOG_LIMIT = 4 * KEY_COUNT;
	localparam int DRAIN_CYCLES   = 32;
	localparam int RANDOM_ITEMS   = 130;
	localparam int MAX_PRINTS     = 100;

	localparam logic [5:0] READ_NONE = 6'd0;
	localparam logic [5:0] READ_ALL  = 6'd63;

	// action codes that the block does not use
	localparam logic [2:0] ACT_SPARE_FIRST = ACT_TICK + 3'd1;
	localparam logic [2:0] ACT_SPARE_LAST  = 3'd7;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               start = 1'b0;
	logic               busy;
	logic [2:0]         action = ACT_PUSH;
	logic [15:0]        event_type = '0;
	logic [15:0]        event_code = '0;
	logic signed [31:0] event_value = '0;
	logic               key_pressed = 1'b0;
	logic [5:0]         read_count = '0;
	logic               result_strobe;
	logic               accepted;
	logic               item_valid;
	logic [15:0]        out_type;
	logic [15:0]        out_code;
	logic signed [31:0] out_value;
	logic [25:0]        ts_sec;
	logic [19:0]        ts_usec;
	logic [5:0]         fill_count;
	logic               dropped_oldest;
	logic               last;

	// 4 ns clock
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	input_event_queue_with_key_state_top DUT (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.action         (action),
		.event_type     (event_type),
		.event_code     (event_code),
		.event_value    (event_value),
		.key_pressed    (key_pressed),
		.read_count     (read_count),
		.result_strobe  (result_strobe),
		.accepted       (accepted),
		.item_valid     (item_valid),
		.out_type       (out_type),
		.out_code       (out_code),
		.out_value      (out_value),
		.ts_sec         (ts_sec),
		.ts_usec        (ts_usec),
		.fill_count     (fill_count),
		.dropped_oldest (dropped_oldest),
		.last           (last)
	);

	// ------------------------------------------------------------------------
	// Behavioral copy of the queue state
	// ------------------------------------------------------------------------
	logic [15:0]        ring_type  [RING_DEPTH];
	logic [15:0]        ring_code  [RING_DEPTH];
	logic signed [31:0] ring_value [RING_DEPTH];
	logic [31:0]        ring_tick  [RING_DEPTH];
	int                 wr_ptr = 0;
	int                 rd_ptr = 0;
	bit                 key_down [KEY_COUNT];
	logic [31:0]        ticks = '0;

	// results still owed by the block, oldest first
	result_t event_results_due[$];

	int mismatch_count = 0;
	int idle_cycles    = 0;
	int burst_left     = 0;

	// Events held: one slot always stays empty, so at most RING_DEPTH-1.
	function automatic int ring_fill();
		return (wr_ptr + RING_DEPTH - rd_ptr) % RING_DEPTH;
	endfunction

	// Queue one event stamped with the current tick; a full ring loses its
	// oldest entry first. Returns whether that happened.
	function automatic logic ring_put(input logic [15:0] t, input logic [15:0] c,
			input logic signed [31:0] v);
		logic drop;
		drop = ((wr_ptr + 1) % RING_DEPTH) == rd_ptr;
		if (drop)
			rd_ptr = (rd_ptr + 1) % RING_DEPTH;
		ring_type[wr_ptr]  = t;
		ring_code[wr_ptr]  = c;
		ring_value[wr_ptr] = v;
		ring_tick[wr_ptr]  = ticks;
		wr_ptr = (wr_ptr + 1) % RING_DEPTH;
		return drop;
	endfunction

	// Apply one accepted item to the copy and queue the results it owes.
	function automatic void apply_event_action(input logic [2:0] act,
			input logic [15:0] et, input logic [15:0] ec,
			input logic signed [31:0] ev, input logic kp, input logic [5:0] rc);
		result_t r;
		result_t popped[$];
		logic    held;
		r = '0;
		if (act == ACT_READ) begin
			while (popped.size() < rc && rd_ptr != wr_ptr) begin
				r = '0;
				r.item_valid = 1'b1;
				r.out_type   = ring_type[rd_ptr];
				r.out_code   = ring_code[rd_ptr];
				r.out_value  = ring_value[rd_ptr];
				// 100 Hz ticks to seconds and microseconds
				r.ts_sec     = 26'(ring_tick[rd_ptr] / TICK_HZ);
				r.ts_usec    = 20'((ring_tick[rd_ptr] % TICK_HZ) * USEC_PER_TICK);
				rd_ptr = (rd_ptr + 1) % RING_DEPTH;
				popped.push_back(r);
			end
			// nothing popped (empty ring or zero count): one invalid result
			if (popped.size() == 0)
				popped.push_back('0);
			// fill is the one after the whole read, on every result
			foreach (popped[i]) begin
				popped[i].fill_count = 6'(ring_fill());
				popped[i].last       = (i == popped.size() - 1);
				event_results_due.push_back(popped[i]);
			end
		end else begin
			case (act)
			ACT_PUSH: begin
				r.dropped_oldest = ring_put(et, ec, ev);
				r.accepted       = 1'b1;
			end
			ACT_KEY: begin
				// out-of-range codes and releases of idle keys are dropped
				if (ec < KEY_COUNT) begin
					held = key_down[ec];
					if (kp || held) begin
						key_down[ec] = kp;
						r.dropped_oldest = ring_put(TYPE_KEY, ec,
							!kp ? VAL_RELEASE : (held ? VAL_REPEAT : VAL_PRESS));
						r.accepted = 1'b1;
					end
				end
			end
			ACT_SYNC: begin
				r.dropped_oldest = ring_put(TYPE_SYNC, CODE_REPORT, VAL_RELEASE);
				r.accepted       = 1'b1;
			end
			ACT_TICK: begin
				ticks = ticks + 32'd1;
			end
			default: begin
			end
			endcase
			r.fill_count = 6'(ring_fill());
			r.last       = 1'b1;
			event_results_due.push_back(r);
		end
	endfunction

	// ------------------------------------------------------------------------
	// Mismatch reporting and result checking
	// ------------------------------------------------------------------------
	task automatic report_mismatch(input string what);
		mismatch_count++;
		if (mismatch_count <= MAX_PRINTS)
			$display("MISMATCH %0d @%0t: %s", mismatch_count, $time, what);
	endtask

	task automatic check_field(input string name, input logic [63:0] got,
			input logic [63:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s: got %0h, expected %0h", name, got, want));
	endtask

	// Results cannot be held off, so every strobe cycle is a transfer.
	// Outputs are sampled at the edge that ends the strobe cycle.
	always @(posedge clk) begin : result_check
		result_t want;
		if (arst_n && result_strobe !== 1'b0) begin
			if (event_results_due.size() == 0) begin
				report_mismatch("result with nothing outstanding");
			end else begin
				want = event_results_due.pop_front();
				check_field("accepted",       accepted,       want.accepted);
				check_field("item_valid",     item_valid,     want.item_valid);
				check_field("out_type",       out_type,       want.out_type);
				check_field("out_code",       out_code,       want.out_code);
				check_field("out_value",      out_value,      want.out_value);
				check_field("ts_sec",         ts_sec,         want.ts_sec);
				check_field("ts_usec",        ts_usec,        want.ts_usec);
				check_field("fill_count",     fill_count,     want.fill_count);
				check_field("dropped_oldest", dropped_oldest, want.dropped_oldest);
				check_field("last",           last,           want.last);
			end
		end
	end

	// Ends the run when no transfer of either kind happens for too long.
	always @(posedge clk) begin : watchdog
		if ((start && busy === 1'b0) || result_strobe === 1'b1)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// Command transfer
	// ------------------------------------------------------------------------
	// Sender works in bursts; between bursts start drops for a random gap,
	// a third of the time not at all. start stays high from one item to the
	// next inside a burst, so it is written once per time step.
	task automatic send_item(input logic [2:0] act, input logic [15:0] et,
			input logic [15:0] ec, input logic signed [31:0] ev, input logic kp,
			input logic [5:0] rc);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
			if (gap != 0) begin
				start <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 16);
		end
		burst_left--;
		start       <= 1'b1;
		action      <= act;
		event_type  <= et;
		event_code  <= ec;
		event_value <= ev;
		key_pressed <= kp;
		read_count  <= rc;
		// busy read at the edge is the value the block saw in that cycle
		do @(posedge clk); while (busy !== 1'b0);
		apply_event_action(act, et, ec, ev, kp, rc);
	endtask

	// Fields an action does not use are still driven at random.
	task automatic send_push(input logic [15:0] t, input logic [15:0] c,
			input logic signed [31:0] v);
		send_item(ACT_PUSH, t, c, v, 1'($urandom), 6'($urandom));
	endtask

	task automatic send_key(input logic [15:0] code, input logic kp);
		send_item(ACT_KEY, 16'($urandom), code, 32'($urandom), kp, 6'($urandom));
	endtask

	task automatic send_read(input logic [5:0] n);
		send_item(ACT_READ, 16'($urandom), 16'($urandom), 32'($urandom),
			1'($urandom), n);
	endtask

	task automatic send_bare(input logic [2:0] act);
		send_item(act, 16'($urandom), 16'($urandom), 32'($urandom),
			1'($urandom), 6'($urandom));
	endtask

	// ------------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------------
	// Corner items: empty reads, field extremes, key press/repeat/release,
	// ignored keys, unused actions, zero-count read, partial and full drain.
	task automatic test_directed();
		send_read(6'd1);
		send_read(READ_NONE);
		send_push(16'hFFFF, 16'hFFFF, 32'sh7FFFFFFF);
		send_push(16'h0000, 16'h0000, 32'sh80000000);
		send_bare(ACT_SYNC);
		send_key(16'd0, 1'b1);
		send_key(16'd0, 1'b1);
		send_key(16'd0, 1'b0);
		send_key(16'd0, 1'b0);
		send_key(16'(KEY_COUNT - 1), 1'b1);
		send_key(16'(KEY_COUNT), 1'b1);
		send_key(16'hFFFF, 1'b1);
		send_key(16'(KEY_COUNT - 1), 1'b0);
		for (int a = ACT_SPARE_FIRST; a <= ACT_SPARE_LAST; a++)
			send_bare(3'(a));
		send_bare(ACT_TICK);
		send_push(16'h5A5A, 16'hA5A5, 32'sh0000_0001);
		send_read(READ_NONE);
		send_read(6'd2);
		send_read(READ_ALL);
		send_read(READ_ALL);
	endtask

	// More pushes than the ring holds, so the oldest entries get dropped;
	// then a short read, another overflow and a full drain.
	task automatic test_ring_overflow();
		for (int i = 0; i < RING_DEPTH + 6; i++) begin
			case (i % 3)
			0: send_push(16'($urandom), 16'($urandom), 32'($urandom));
			1: send_key(16'($urandom_range(0, 15)), 1'b1);
			default: send_bare(ACT_SYNC);
			endcase
			if (i % 8 == 5)
				send_bare(ACT_TICK);
		end
		send_read(6'd5);
		for (int i = 0; i < 10; i++)
			send_push(16'($urandom), 16'($urandom), 32'($urandom));
		send_read(READ_ALL);
		send_read(READ_ALL);
	endtask

	// Enough ticks to carry the seconds count over a few seconds, events in
	// between.
	task automatic test_timebase();
		for (int i = 0; i < 240; i++) begin
			send_bare(ACT_TICK);
			if (i % 40 == 7) begin
				send_push(16'($urandom), 16'($urandom), 32'($urandom));
				send_key(16'($urandom_range(0, 15)), 1'($urandom));
			end
		end
		send_bare(ACT_SYNC);
		send_read(READ_ALL);
	endtask

	// Mixed traffic. Key codes sit mostly in a small set so presses, repeats
	// and releases of held keys are common; some land near or past the top
	// of the key map. Occasional push floods can fill the ring to overflow.
	task automatic test_random();
		int          sel;
		int          pick;
		int          run;
		logic [15:0] code;
		logic [5:0]  n;
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			sel = $urandom_range(0, 99);
			if (sel < 3) begin
				run = $urandom_range(20, 60);
				repeat (run)
					send_push(16'($urandom), 16'($urandom), 32'($urandom));
				i += run - 1;
			end else if (sel < 25) begin
				send_push(16'($urandom), 16'($urandom), 32'($urandom));
			end else if (sel < 55) begin
				pick = $urandom_range(0, 9);
				if (pick < 7)
					code = 16'($urandom_range(0, 15));
				else if (pick < 8)
					code = 16'($urandom_range(KEY_COUNT - 8, KEY_COUNT + 7));
				else
					code = 16'($urandom);
				send_key(code, 1'($urandom));
			end else if (sel < 64) begin
				send_bare(ACT_SYNC);
			end else if (sel < 80) begin
				pick = $urandom_range(0, 9);
				if (pick < 5)
					n = 6'($urandom_range(1, 4));
				else if (pick < 8)
					n = 6'($urandom);
				else
					n = READ_ALL;
				send_read(n);
			end else if (sel < 95) begin
				send_bare(ACT_TICK);
			end else begin
				send_bare(3'($urandom_range(ACT_SPARE_FIRST, ACT_SPARE_LAST)));
			end
		end
	endtask

	// ------------------------------------------------------------------------
	// Sequence
	// ------------------------------------------------------------------------
	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// busy holds the first item off during the key map sweep
		test_directed();
		test_ring_overflow();
		test_timebase();
		test_random();
		start <= 1'b0;
		while (event_results_due.size() != 0)
			@(posedge clk);
		// catch any stray result past the last one owed
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
